// ===== sv/complex_vector_normalizer_assert.svh =====
// Assertion macros for the vector normalizer.
`ifndef COMPLEX_VECTOR_NORMALIZER_ASSERT_SVH
`define COMPLEX_VECTOR_NORMALIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define CVN_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define CVN_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/cvn_pkg.sv =====
package cvn_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int GRID_BITS     = 16;
    localparam int SUM_BITS      = 44;
    localparam int SCALE_BITS    = 24;
    localparam int PROD_BITS     = SUM_BITS + GRID_BITS;       // 60
    localparam int MUL_BITS      = SAMPLE_BITS + SCALE_BITS + 1;
    localparam int SQ_BITS       = 2 * SAMPLE_BITS;
    localparam int QUO_BITS      = 48;
    localparam int DIV_STEPS     = 77;
    localparam int ROOT_STEPS    = 24;
    localparam int CNT_BITS      = 7;
    localparam int IN_DATA_BITS  = 32;
    localparam int OUT_DATA_BITS = 80;

    localparam logic [GRID_BITS-1:0]  GRID_RESET  = 16'd655;
    localparam logic [SCALE_BITS-1:0] SCALE_ONE   = 24'h01_0000;
    localparam logic [SCALE_BITS-1:0] SCALE_MAX   = 24'hFF_FFFF;
    localparam logic [SUM_BITS-1:0]   SUM_MAX     = {SUM_BITS{1'b1}};
    localparam logic [PROD_BITS-1:0]  SMALL_LIMIT = 60'h1 << 28;
    localparam logic [QUO_BITS-1:0]   ROOT_PROBE0 = 48'h1 << 46;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_NORM,
        ST_PROD,
        ST_CHECK,
        ST_DIV,
        ST_ROOT_INIT,
        ST_ROOT,
        ST_REPORT
    } ctrl_state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACC,
        OP_NORM,
        OP_PROD,
        OP_DIV_INIT,
        OP_DIV,
        OP_ROOT_INIT,
        OP_ROOT,
        OP_REPORT
    } dp_op_t;

    typedef struct packed {
        logic   take;
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic p_zero;
        logic p_small;
        logic div_done;
        logic root_done;
        logic out_free;
    } dp_status_t;

endpackage

// ===== sv/cvn_ctrl.sv =====
module cvn_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tuser,
    output logic                s_tready,
    input  cvn_pkg::dp_status_t status,
    output cvn_pkg::dp_cmd_t    cmd
);

    cvn_pkg::ctrl_state_t state_reg;
    cvn_pkg::ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cvn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cvn_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = s_tuser ? cvn_pkg::ST_NORM : cvn_pkg::ST_ACC;
                end
            end
            cvn_pkg::ST_ACC:
            begin
                state_next = status.last ? cvn_pkg::ST_PROD : cvn_pkg::ST_IDLE;
            end
            cvn_pkg::ST_NORM:
            begin
                if (status.out_free)
                begin
                    state_next = cvn_pkg::ST_IDLE;
                end
            end
            cvn_pkg::ST_PROD:
            begin
                state_next = cvn_pkg::ST_CHECK;
            end
            cvn_pkg::ST_CHECK:
            begin
                state_next = status.p_small ? cvn_pkg::ST_REPORT : cvn_pkg::ST_DIV;
            end
            cvn_pkg::ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = cvn_pkg::ST_ROOT_INIT;
                end
            end
            cvn_pkg::ST_ROOT_INIT:
            begin
                state_next = cvn_pkg::ST_ROOT;
            end
            cvn_pkg::ST_ROOT:
            begin
                if (status.root_done)
                begin
                    state_next = cvn_pkg::ST_REPORT;
                end
            end
            cvn_pkg::ST_REPORT:
            begin
                if (status.out_free)
                begin
                    state_next = cvn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cvn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        s_tready = 1'b0;
        cmd.op   = cvn_pkg::OP_NONE;
        unique case (state_reg)
            cvn_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            cvn_pkg::ST_ACC:
            begin
                cmd.op = cvn_pkg::OP_ACC;
            end
            cvn_pkg::ST_NORM:
            begin
                cmd.op = status.out_free ? cvn_pkg::OP_NORM : cvn_pkg::OP_NONE;
            end
            cvn_pkg::ST_PROD:
            begin
                cmd.op = cvn_pkg::OP_PROD;
            end
            cvn_pkg::ST_CHECK:
            begin
                cmd.op = status.p_small ? cvn_pkg::OP_NONE : cvn_pkg::OP_DIV_INIT;
            end
            cvn_pkg::ST_DIV:
            begin
                cmd.op = cvn_pkg::OP_DIV;
            end
            cvn_pkg::ST_ROOT_INIT:
            begin
                cmd.op = cvn_pkg::OP_ROOT_INIT;
            end
            cvn_pkg::ST_ROOT:
            begin
                cmd.op = cvn_pkg::OP_ROOT;
            end
            cvn_pkg::ST_REPORT:
            begin
                cmd.op = status.out_free ? cvn_pkg::OP_REPORT : cvn_pkg::OP_NONE;
            end
            default:
            begin
                cmd.op = cvn_pkg::OP_NONE;
            end
        endcase
        cmd.take = s_tvalid & s_tready;
    end

endmodule

// ===== sv/cvn_datapath.sv =====
module cvn_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [cvn_pkg::GRID_BITS-1:0]         cfg_wr_data,
    input  logic [cvn_pkg::IN_DATA_BITS-1:0]      s_tdata,
    input  logic                                  s_tuser,
    input  logic                                  s_tlast,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [cvn_pkg::OUT_DATA_BITS-1:0]     m_tdata,
    output logic                                  m_tuser,
    input  cvn_pkg::dp_cmd_t                      cmd,
    output cvn_pkg::dp_status_t                   status
);

    localparam int SB  = cvn_pkg::SAMPLE_BITS;
    localparam int MB  = cvn_pkg::MUL_BITS;
    localparam int PB  = cvn_pkg::PROD_BITS;
    localparam int QB  = cvn_pkg::QUO_BITS;
    localparam int SUB = cvn_pkg::SUM_BITS;
    localparam int SCB = cvn_pkg::SCALE_BITS;
    localparam int RB  = MB - 16;   // width after dropping 16 fraction bits

    localparam logic signed [SB-1:0] OUT_HI = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] OUT_LO = {1'b1, {(SB-1){1'b0}}};

    // control / architectural state
    logic [cvn_pkg::GRID_BITS-1:0] grid_reg, grid_next;
    logic [SUB-1:0]                sum_reg, sum_next;
    logic [SCB-1:0]                scale_reg, scale_next;
    logic                          zero_reg, zero_next;
    logic                          last_reg, last_next;
    logic [cvn_pkg::CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic                          out_valid_reg, out_valid_next;

    // payload
    logic signed [MB-1:0]          prod_re_reg, prod_re_next;
    logic signed [MB-1:0]          prod_im_reg, prod_im_next;
    logic [PB-1:0]                 p_reg, p_next;
    logic [PB-1:0]                 rem_reg, rem_next;
    logic [QB-1:0]                 quo_reg, quo_next;
    logic [QB-1:0]                 q_reg, q_next;
    logic [QB-1:0]                 root_reg, root_next;
    logic [QB-1:0]                 probe_reg, probe_next;
    logic                          out_kind_reg, out_kind_next;
    logic [SB-1:0]                 out_re_reg, out_re_next;
    logic [SB-1:0]                 out_im_reg, out_im_next;
    logic [SUB-1:0]                out_sum_reg, out_sum_next;
    logic                          out_zero_reg, out_zero_next;
    logic                          out_clip_reg, out_clip_next;

    // input multipliers: squares when accumulating, times scale when normalizing
    logic signed [SB-1:0]    in_re, in_im;
    logic signed [SCB:0]     mul_b_re, mul_b_im;
    logic signed [MB-1:0]    mul_re, mul_im;

    assign in_re    = $signed(s_tdata[SB-1:0]);
    assign in_im    = $signed(s_tdata[2*SB-1:SB]);
    assign mul_b_re = s_tuser ? $signed({1'b0, scale_reg})
                              : $signed({{(SCB+1-SB){in_re[SB-1]}}, in_re});
    assign mul_b_im = s_tuser ? $signed({1'b0, scale_reg})
                              : $signed({{(SCB+1-SB){in_im[SB-1]}}, in_im});
    assign mul_re   = in_re * mul_b_re;
    assign mul_im   = in_im * mul_b_im;

    // accumulate with saturation
    logic [SUB:0] acc_sum;
    assign acc_sum = {1'b0, sum_reg}
                   + {{(SUB+1-cvn_pkg::SQ_BITS){1'b0}}, prod_re_reg[cvn_pkg::SQ_BITS-1:0]}
                   + {{(SUB+1-cvn_pkg::SQ_BITS){1'b0}}, prod_im_reg[cvn_pkg::SQ_BITS-1:0]};

    logic [PB-1:0] p_full;
    assign p_full = sum_reg * grid_reg;

    // restoring divide step for floor(2^76 / p)
    logic [PB:0] rem_sh, rem_diff;
    logic        rem_ge;
    assign rem_sh   = {rem_reg, (cnt_reg == '0)};
    assign rem_diff = rem_sh - {1'b0, p_reg};
    assign rem_ge   = (rem_sh >= {1'b0, p_reg});

    // digit-by-digit square root step
    logic [QB-1:0] root_trial;
    logic          root_ge;
    assign root_trial = root_reg + probe_reg;
    assign root_ge    = (q_reg >= root_trial);

    // round half up then saturate
    logic signed [MB-1:0] rnd_re, rnd_im;
    logic signed [RB-1:0] sh_re, sh_im;
    logic signed [SB-1:0] sat_re, sat_im;
    logic                 clip_re, clip_im;

    assign rnd_re = prod_re_reg + $signed({{(MB-16){1'b0}}, 16'h8000});
    assign rnd_im = prod_im_reg + $signed({{(MB-16){1'b0}}, 16'h8000});
    assign sh_re  = rnd_re[MB-1:16];
    assign sh_im  = rnd_im[MB-1:16];

    always_comb
    begin
        clip_re = 1'b1;
        if (sh_re > RB'(OUT_HI))
        begin
            sat_re = OUT_HI;
        end
        else if (sh_re < RB'(OUT_LO))
        begin
            sat_re = OUT_LO;
        end
        else
        begin
            sat_re  = sh_re[SB-1:0];
            clip_re = 1'b0;
        end
        clip_im = 1'b1;
        if (sh_im > RB'(OUT_HI))
        begin
            sat_im = OUT_HI;
        end
        else if (sh_im < RB'(OUT_LO))
        begin
            sat_im = OUT_LO;
        end
        else
        begin
            sat_im  = sh_im[SB-1:0];
            clip_im = 1'b0;
        end
    end

    always_comb
    begin
        grid_next      = cfg_wr_en ? cfg_wr_data : grid_reg;
        sum_next       = sum_reg;
        scale_next     = scale_reg;
        zero_next      = zero_reg;
        last_next      = last_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        prod_re_next   = prod_re_reg;
        prod_im_next   = prod_im_reg;
        p_next         = p_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        q_next         = q_reg;
        root_next      = root_reg;
        probe_next     = probe_reg;
        out_kind_next  = out_kind_reg;
        out_re_next    = out_re_reg;
        out_im_next    = out_im_reg;
        out_sum_next   = out_sum_reg;
        out_zero_next  = out_zero_reg;
        out_clip_next  = out_clip_reg;

        if (cmd.take)
        begin
            prod_re_next = mul_re;
            prod_im_next = mul_im;
            last_next    = s_tlast;
        end

        unique case (cmd.op)
            cvn_pkg::OP_NONE:
            begin
            end
            cvn_pkg::OP_ACC:
            begin
                sum_next = acc_sum[SUB] ? cvn_pkg::SUM_MAX : acc_sum[SUB-1:0];
            end
            cvn_pkg::OP_NORM:
            begin
                out_valid_next = 1'b1;
                out_kind_next  = 1'b1;
                out_re_next    = sat_re;
                out_im_next    = sat_im;
                out_sum_next   = '0;
                out_zero_next  = zero_reg;
                out_clip_next  = clip_re | clip_im;
            end
            cvn_pkg::OP_PROD:
            begin
                p_next = p_full;
            end
            cvn_pkg::OP_DIV_INIT:
            begin
                rem_next = '0;
                quo_next = '0;
                cnt_next = '0;
            end
            cvn_pkg::OP_DIV:
            begin
                rem_next = rem_ge ? rem_diff[PB-1:0] : rem_sh[PB-1:0];
                // quotient is known to stay below 2^48
                quo_next = {quo_reg[QB-2:0], rem_ge};
                cnt_next = cnt_reg + 1'b1;
            end
            cvn_pkg::OP_ROOT_INIT:
            begin
                q_next     = quo_reg;
                root_next  = '0;
                probe_next = cvn_pkg::ROOT_PROBE0;
                cnt_next   = '0;
            end
            cvn_pkg::OP_ROOT:
            begin
                if (root_ge)
                begin
                    q_next    = q_reg - root_trial;
                    root_next = (root_reg >> 1) + probe_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                probe_next = probe_reg >> 2;
                cnt_next   = cnt_reg + 1'b1;
            end
            cvn_pkg::OP_REPORT:
            begin
                if (status.p_small || (|root_reg[QB-1:SCB]))
                begin
                    scale_next = cvn_pkg::SCALE_MAX;
                end
                else
                begin
                    scale_next = root_reg[SCB-1:0];
                end
                zero_next      = status.p_zero;
                sum_next       = '0;
                out_valid_next = 1'b1;
                out_kind_next  = 1'b0;
                out_re_next    = '0;
                out_im_next    = '0;
                out_sum_next   = sum_reg;
                out_zero_next  = status.p_zero;
                out_clip_next  = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_reg      <= cvn_pkg::GRID_RESET;
            sum_reg       <= '0;
            scale_reg     <= cvn_pkg::SCALE_ONE;
            zero_reg      <= 1'b0;
            last_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            grid_reg      <= grid_next;
            sum_reg       <= sum_next;
            scale_reg     <= scale_next;
            zero_reg      <= zero_next;
            last_reg      <= last_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_re_reg  <= prod_re_next;
        prod_im_reg  <= prod_im_next;
        p_reg        <= p_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        q_reg        <= q_next;
        root_reg     <= root_next;
        probe_reg    <= probe_next;
        out_kind_reg <= out_kind_next;
        out_re_reg   <= out_re_next;
        out_im_reg   <= out_im_next;
        out_sum_reg  <= out_sum_next;
        out_zero_reg <= out_zero_next;
        out_clip_reg <= out_clip_next;
    end

    assign status.last      = last_reg;
    assign status.p_zero    = (p_reg == '0);
    assign status.p_small   = (p_reg <= cvn_pkg::SMALL_LIMIT);
    assign status.div_done  = (cnt_reg == cvn_pkg::CNT_BITS'(cvn_pkg::DIV_STEPS - 1));
    assign status.root_done = (cnt_reg == cvn_pkg::CNT_BITS'(cvn_pkg::ROOT_STEPS - 1));
    assign status.out_free  = ~out_valid_reg | m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_clip_reg, out_zero_reg, out_sum_reg, out_im_reg, out_re_reg};

endmodule

// ===== sv/complex_vector_normalizer.sv =====
// A scaled sample is registered at its input transfer, then written to the output
// register once that is free; an accumulate sample is added to the sum. The last
// one leads to a norm report when sum*dx <= 2^-16, else after 77 restoring divide
// steps and 24 square root steps. No new sample is taken until the last is done.
// Reset (rst_n low, asynchronous): sum 0, scale 1.0, zero flag 0, dx = 655,
// output empty.
`include "complex_vector_normalizer_assert.svh"

module complex_vector_normalizer (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [cvn_pkg::GRID_BITS-1:0]     cfg_wr_data,   // grid_step
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [cvn_pkg::IN_DATA_BITS-1:0]  s_tdata,       // sample_real, sample_imag
    input  logic                              s_tuser,       // cmd
    input  logic                              s_tlast,       // is_last
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_real, out_imag, norm_sum, zero_norm, clipped, 2 pad bits
    output logic [cvn_pkg::OUT_DATA_BITS-1:0] m_tdata,
    output logic                              m_tuser        // kind
);

    cvn_pkg::dp_cmd_t    ctrl_cmd;
    cvn_pkg::dp_status_t dp_status;

    cvn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    cvn_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cmd         (ctrl_cmd),
        .status      (dp_status)
    );

    // one item in flight: no back-to-back input transfers
    `CVN_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "input taken while busy")

    // a result op always leaves a valid result in the output register
    `CVN_ASSERT_NEXT(a_result_held,
        ctrl_cmd.op == cvn_pkg::OP_NORM || ctrl_cmd.op == cvn_pkg::OP_REPORT,
        m_tvalid, "result op lost")

    // the last divide step hands off to the square root
    `CVN_ASSERT_NEXT(a_div_to_root,
        ctrl_cmd.op == cvn_pkg::OP_DIV && dp_status.div_done,
        ctrl_cmd.op == cvn_pkg::OP_ROOT_INIT, "divide did not hand off")

    // no input transfer while the datapath is busy with an op
    `CVN_ASSERT_NOW(a_idle_take, ctrl_cmd.take, ctrl_cmd.op == cvn_pkg::OP_NONE,
        "take during datapath op")

endmodule

// ===== tb/cvn_tb_pkg.sv =====
`timescale 1ns / 100ps

package cvn_tb_pkg;

    // Sample command, carried on s_tuser.
    typedef enum logic {
        CMD_ACCUM = 1'b0,
        CMD_SCALE = 1'b1
    } sample_cmd_t;

    // Result kind, carried on m_tuser.
    typedef enum logic {
        KIND_NORM   = 1'b0,
        KIND_SAMPLE = 1'b1
    } result_kind_t;

endpackage

// ===== tb/cvn_checker.sv =====
`timescale 1ns / 100ps

module cvn_checker
    import cvn_pkg::*;
    import cvn_tb_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_wr_en,
    input  logic [GRID_BITS-1:0]     cfg_wr_data,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    input  logic                     s_tuser,
    input  logic                     s_tlast,
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_DATA_BITS-1:0] m_tdata,
    input  logic                     m_tuser,
    output int                       error_count,
    output int                       pending
);

    localparam int MAX_REPORTS = 10;
    localparam int IM_LSB      = SAMPLE_BITS;
    localparam int SUM_LSB     = 2 * SAMPLE_BITS;
    localparam int ZERO_BIT    = SUM_LSB + SUM_BITS;
    localparam int CLIP_BIT    = ZERO_BIT + 1;
    localparam longint PART_HI = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint PART_LO = -PART_HI - 1;

    typedef struct {
        logic                          kind;
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic [SUM_BITS-1:0]           sum;
        logic                          zero;
        logic                          clip;
    } norm_result_t;

    norm_result_t           awaited_results[$];
    logic [GRID_BITS-1:0]   grid_step;
    logic [SUM_BITS-1:0]    square_sum;
    logic [SCALE_BITS-1:0]  scale_q8_16;
    logic                   norm_zero;

    // floor(2^38 / sqrt(p)) as the integer root of floor(2^76 / p)
    function automatic logic [SCALE_BITS-1:0] inv_root_scale(input logic [PROD_BITS-1:0] p);
        logic [79:0]           quotient;
        logic [79:0]           trial_sq;
        logic [SCALE_BITS-1:0] root;
        logic [SCALE_BITS-1:0] trial;
        if (p <= SMALL_LIMIT)
            return SCALE_MAX;
        quotient = (80'd1 << 76) / {20'd0, p};
        root = '0;
        for (int b = SCALE_BITS - 1; b >= 0; b--)
        begin
            trial = root | (SCALE_BITS'(1) << b);
            trial_sq = {56'd0, trial} * {56'd0, trial};
            if (trial_sq <= quotient)
                root = trial;
        end
        return root;
    endfunction

    // round half up, then saturate to the sample range
    function automatic logic [SAMPLE_BITS-1:0] scale_part(input logic signed [SAMPLE_BITS-1:0] x,
                                                          inout logic clip);
        longint prod;
        prod = longint'(x) * longint'(scale_q8_16) + (longint'(1) << 15);
        prod = prod >>> 16;
        if (prod > PART_HI)
        begin
            clip = 1'b1;
            prod = PART_HI;
        end
        else if (prod < PART_LO)
        begin
            clip = 1'b1;
            prod = PART_LO;
        end
        return SAMPLE_BITS'(prod);
    endfunction

    task automatic predict_transfer();
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
        logic [SUM_BITS-1:0]           mag;
        logic [PROD_BITS-1:0]          prod;
        norm_result_t                  r;
        re = s_tdata[IM_LSB-1:0];
        im = s_tdata[SUM_LSB-1:IM_LSB];
        if (s_tuser == CMD_ACCUM)
        begin
            mag = SUM_BITS'(longint'(re) * re + longint'(im) * im);
            if (mag > SUM_MAX - square_sum)
                square_sum = SUM_MAX;
            else
                square_sum = square_sum + mag;
            if (!s_tlast)
                return;
            prod = PROD_BITS'(square_sum) * PROD_BITS'(grid_step);
            if (prod == '0)
            begin
                scale_q8_16 = SCALE_MAX;
                norm_zero = 1'b1;
            end
            else
            begin
                scale_q8_16 = inv_root_scale(prod);
                norm_zero = 1'b0;
            end
            r.kind = KIND_NORM;
            r.re = '0;
            r.im = '0;
            r.sum = square_sum;
            r.zero = norm_zero;
            r.clip = 1'b0;
            square_sum = '0;
        end
        else
        begin
            // is_last means nothing in the scale pass
            r.kind = KIND_SAMPLE;
            r.clip = 1'b0;
            r.re = scale_part(re, r.clip);
            r.im = scale_part(im, r.clip);
            r.sum = '0;
            r.zero = norm_zero;
        end
        awaited_results.push_back(r);
    endtask

    task automatic check_transfer();
        norm_result_t want;
        norm_result_t got;
        got.kind = m_tuser;
        got.re = m_tdata[IM_LSB-1:0];
        got.im = m_tdata[SUM_LSB-1:IM_LSB];
        got.sum = m_tdata[ZERO_BIT-1:SUM_LSB];
        got.zero = m_tdata[ZERO_BIT];
        got.clip = m_tdata[CLIP_BIT];
        if (awaited_results.size() == 0)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
                $display("%0t: unexpected result kind %0b re %0d im %0d sum %0d zero %0b clip %0b",
                         $time, got.kind, got.re, got.im, got.sum, got.zero, got.clip);
            return;
        end
        want = awaited_results.pop_front();
        if (got.kind !== want.kind || got.re !== want.re || got.im !== want.im ||
            got.sum !== want.sum || got.zero !== want.zero || got.clip !== want.clip)
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
            begin
                $display("%0t: mismatch, expected kind %0b re %0d im %0d sum %0d zero %0b clip %0b",
                         $time, want.kind, want.re, want.im, want.sum, want.zero, want.clip);
                $display("%0t:           got kind %0b re %0d im %0d sum %0d zero %0b clip %0b",
                         $time, got.kind, got.re, got.im, got.sum, got.zero, got.clip);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_results.delete();
            grid_step = GRID_RESET;
            square_sum = '0;
            scale_q8_16 = SCALE_ONE;
            norm_zero = 1'b0;
            error_count = 0;
            pending = 0;
        end
        else
        begin
            // check before predicting so a stray result never meets a fresh expectation
            if (m_tvalid && m_tready)
                check_transfer();
            if (cfg_wr_en)
                grid_step = cfg_wr_data;
            if (s_tvalid && s_tready)
                predict_transfer();
            pending = awaited_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    import cvn_pkg::*;
    import cvn_tb_pkg::*;

    localparam int     ITEM_TARGET   = 1700;
    localparam int     HOLD_CYCLES   = 400;
    localparam int     CFG_SETTLE    = 8;     // long enough for an accumulate sample to finish
    localparam int     DRAIN_CYCLES  = 150;   // longer than a full norm report
    localparam longint RUN_LIMIT_NS  = 20_000_000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [GRID_BITS-1:0]     cfg_wr_data = '0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata = '0;
    logic                     s_tuser = 1'b0;
    logic                     s_tlast = 1'b0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     m_tuser;

    int   chk_errors;
    int   chk_pending;
    int   items_sent = 0;
    logic tx_steady = 1'b0;
    logic rx_steady = 1'b0;
    logic hold_req = 1'b0;

    always #2 clk = ~clk;

    complex_vector_normalizer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    cvn_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .error_count (chk_errors),
        .pending     (chk_pending)
    );

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Some tests failed");
        $finish;
    end

    function automatic int idle_len(input logic steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 12)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // receiver: random stalls, or one long hold-off when asked
    initial
    begin
        int on_len;
        int off_len;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                on_len = $urandom_range(1, 20);
                off_len = idle_len(rx_steady);
                m_tready <= 1'b1;
                repeat (on_len) @(posedge clk);
                if (off_len > 0)
                begin
                    m_tready <= 1'b0;
                    repeat (off_len) @(posedge clk);
                end
            end
        end
    end

    // signed part limited to amp+1 significant bits
    function automatic logic [SAMPLE_BITS-1:0] rand_part(input int amp);
        logic signed [SAMPLE_BITS-1:0] v;
        v = SAMPLE_BITS'($urandom);
        return v >>> (SAMPLE_BITS - 1 - amp);
    endfunction

    function automatic logic [GRID_BITS-1:0] pick_grid();
        case ($urandom_range(0, 7))
            0: return GRID_BITS'(1);
            1: return '1;
            2: return '0;
            3: return GRID_RESET;
            default: return GRID_BITS'($urandom_range(1, 65535));
        endcase
    endfunction

    task automatic send_sample(input sample_cmd_t cmd, input logic [SAMPLE_BITS-1:0] re,
                               input logic [SAMPLE_BITS-1:0] im, input logic last);
        int gap;
        gap = idle_len(tx_steady);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {im, re};
        s_tuser <= cmd;
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        items_sent++;
    endtask

    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        do @(posedge clk); while (chk_pending != 0);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_grid(input logic [GRID_BITS-1:0] value);
        drain_results(CFG_SETTLE);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // accumulate pass then scale pass; a broken one has scale transfers
    // wedged in before one of the accumulate transfers
    task automatic run_vector(input int len, input int amp, input logic broken);
        int split;
        int extra;
        int scale_len;
        int scale_amp;
        split = broken ? $urandom_range(0, len - 1) : -1;
        extra = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
        begin
            if (i == split)
                for (int k = 0; k < extra; k++)
                    send_sample(CMD_SCALE, rand_part(15), rand_part(15),
                                1'($urandom_range(0, 1)));
            send_sample(CMD_ACCUM, rand_part(amp), rand_part(amp), i == len - 1);
        end
        scale_len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, len) : len;
        scale_amp = ($urandom_range(0, 3) == 0) ? 15 : amp;
        for (int i = 0; i < scale_len; i++)
            send_sample(CMD_SCALE, rand_part(scale_amp), rand_part(scale_amp),
                        1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int len;
        int amp;
        int pick;
        wait (rst_n === 1'b1);
        @(posedge clk);

        // scale of one after reset; is_last has no effect on a scale transfer
        send_sample(CMD_SCALE, 16'sd1, -16'sd1, 1'b0);
        send_sample(CMD_SCALE, 16'sd32767, -16'sd32768, 1'b1);
        // empty vector: zero flag and saturated scale, then clipping
        send_sample(CMD_ACCUM, 16'sd0, 16'sd0, 1'b1);
        send_sample(CMD_SCALE, 16'sd1, -16'sd1, 1'b0);
        send_sample(CMD_SCALE, 16'sd32767, -16'sd32768, 1'b0);
        send_sample(CMD_SCALE, 16'sd0, 16'sd0, 1'b0);
        // tiny product saturates the scale without the zero flag
        send_sample(CMD_ACCUM, 16'sd1, 16'sd0, 1'b1);
        send_sample(CMD_SCALE, -16'sd1, 16'sd2, 1'b0);
        write_grid('1);
        send_sample(CMD_ACCUM, -16'sd32768, -16'sd32768, 1'b0);
        send_sample(CMD_ACCUM, -16'sd32768, -16'sd32768, 1'b0);
        send_sample(CMD_ACCUM, 16'sd32767, 16'sd32767, 1'b1);
        send_sample(CMD_SCALE, 16'sd16384, -16'sd16384, 1'b0);
        send_sample(CMD_SCALE, -16'sd32768, 16'sd32767, 1'b0);
        // zero grid step with a nonzero sum
        write_grid('0);
        send_sample(CMD_ACCUM, 16'sd16384, 16'sd0, 1'b1);
        send_sample(CMD_SCALE, 16'sd1, 16'sd1, 1'b0);
        // product just above the small-product bound
        write_grid(GRID_BITS'(1));
        send_sample(CMD_ACCUM, 16'sd16384, 16'sd0, 1'b0);
        send_sample(CMD_ACCUM, 16'sd0, 16'sd16384, 1'b1);
        send_sample(CMD_SCALE, 16'sd16384, -16'sd16384, 1'b0);
        send_sample(CMD_SCALE, 16'sd8192, -16'sd1, 1'b0);
        write_grid(GRID_RESET);

        // back-pressure: sender keeps going while the receiver holds off
        tx_steady = 1'b1;
        hold_req = 1'b1;
        run_vector(40, 12, 1'b0);
        drain_results(0);
        tx_steady = 1'b0;

        while (items_sent < ITEM_TARGET)
        begin
            tx_steady = ($urandom_range(0, 5) == 0);
            rx_steady = ($urandom_range(0, 5) == 0);
            if ($urandom_range(0, 3) == 0)
                write_grid(pick_grid());
            len = ($urandom_range(0, 14) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
            amp = ($urandom_range(0, 2) == 0) ? 15 : $urandom_range(0, 15);
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                for (int i = 0; i < len; i++)
                    send_sample(CMD_SCALE, rand_part(amp), rand_part(amp),
                                1'($urandom_range(0, 1)));
            end
            else
                run_vector(len, amp, pick == 1);
            if ($urandom_range(0, 7) == 0)
                drain_results(0);
        end

        drain_results(DRAIN_CYCLES);
        if (chk_errors == 0 && chk_pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== complex_vector_normalizer.f =====
+incdir+sv
sv/cvn_pkg.sv
sv/cvn_ctrl.sv
sv/cvn_datapath.sv
sv/complex_vector_normalizer.sv
tb/cvn_tb_pkg.sv
tb/cvn_checker.sv
tb/tb_top.sv
